FILE: src/pspm_pkg.sv
`default_nettype none

package pspm_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int TICKS_WIDTH     = 16;
   localparam int CONTEXT_WIDTH   = 5;

   localparam logic [TICKS_WIDTH-1:0] LINGER_TICKS_RESET = 16'd5000;
   localparam logic [TICKS_WIDTH-1:0] WARMUP_TICKS_RESET = 16'd500;

   typedef enum logic [2:0] {
      MODE_READING       = 3'd0,
      MODE_TICK          = 3'd1,
      MODE_CONTEXT       = 3'd2,
      MODE_REASON_ADD    = 3'd3,
      MODE_REASON_REMOVE = 3'd4,
      MODE_REEVALUATE    = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      STATE_UNDEFINED = 2'd0,
      STATE_OPEN      = 2'd1,
      STATE_CLOSED    = 2'd2
   } cover_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SENSOR_IN_USE = 3'd0,
      CSR_ON_DEMAND     = 3'd1,
      CSR_ACTS_AS_LID   = 3'd2,
      CSR_LINGER_TICKS  = 3'd3,
      CSR_WARMUP_TICKS  = 3'd4
   } csr_index_type;

endpackage

`default_nettype wire

FILE: src/proximity_sensor_power_manager.sv
// Proximity sensor power manager.
// Request channel (req_valid / req_stall) carries one event per request:
// a sensor reading, a timer tick, a context update, a reason add or remove,
// or a re-evaluate command. Response channel (rsp_valid / rsp_stall) returns
// exactly one response per request: the published proximity and lid states
// and the power, warm-up and linger status after that request.
// Configuration registers are written through csr_write / csr_index /
// csr_data; the user must write them only while no request is in flight,
// which the block itself does not enforce; unknown indexes are dropped.
// A request taken into the request register is processed into the response
// register when that register can advance. One request per cycle is taken
// while the receiver does not stall; the state update is combinational.
// When the receiver stalls, the response register holds and the request
// register keeps one more request; req_stall rises only when both are full.
// Synchronous reset powers the sensor off, clears reasons and context,
// publishes undefined on both outputs and loads the default register values.
`default_nettype none

module proximity_sensor_power_manager
   import pspm_pkg::*;
#(
   parameter int MAX_REASONS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data,

   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [2:0]                 req_mode,
   input  wire logic                       req_covered,
   input  wire logic                       req_lpm_next,
   input  wire logic                       req_lpm_current,
   input  wire logic                       req_call_live,
   input  wire logic                       req_alarm_live,
   input  wire logic                       req_ui_exception,
   input  wire logic [3:0]                 req_reason_id,

   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_proximity_state,
   output logic [1:0]                      rsp_lid_state,
   output logic                            rsp_sensor_powered,
   output logic                            rsp_warming_up,
   output logic                            rsp_lingering
);

   logic                     sensor_in_use_ff;
   logic                     on_demand_ff;
   logic                     acts_as_lid_ff;
   logic [TICKS_WIDTH-1:0]   linger_ticks_ff;
   logic [TICKS_WIDTH-1:0]   warmup_ticks_ff;

   logic                     req_valid_ff, req_valid_in;
   logic [2:0]               req_mode_ff;
   logic                     req_covered_ff;
   logic [CONTEXT_WIDTH-1:0] req_context_ff;
   logic [3:0]               req_reason_id_ff;

   logic                     powered_ff, powered_in;
   logic [TICKS_WIDTH-1:0]   warmup_left_ff, warmup_left_in;
   logic                     warmup_running_ff, warmup_running_in;
   logic [TICKS_WIDTH-1:0]   linger_left_ff, linger_left_in;
   logic                     linger_running_ff, linger_running_in;
   logic [1:0]               last_reading_ff, last_reading_in;
   logic [1:0]               prox_out_ff, prox_out_in;
   logic [1:0]               lid_out_ff, lid_out_in;
   logic [MAX_REASONS-1:0]   reason_bits_ff, reason_bits_in;
   logic [CONTEXT_WIDTH-1:0] context_flags_ff, context_flags_in;

   logic                     rsp_valid_ff;
   logic [1:0]               rsp_proximity_state_ff;
   logic [1:0]               rsp_lid_state_ff;
   logic                     rsp_sensor_powered_ff;
   logic                     rsp_warming_up_ff;
   logic                     rsp_lingering_ff;

   logic                     advance;
   logic                     fire;
   logic                     req_take;
   logic [MAX_REASONS-1:0]   reason_hit;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_REASONS; i++) begin
         reason_hit[i] = (32'(req_reason_id_ff) == i);
      end
   end

   // next state for the request in the request register
   always_comb begin : p_next
      logic       reeval_en;
      logic       power_on;
      logic       power_set;
      logic [1:0] pub_value;
      logic       pub_en;

      reeval_en         = 1'b0;
      power_on          = 1'b0;
      power_set         = 1'b0;
      pub_value         = STATE_UNDEFINED;
      pub_en            = 1'b0;

      powered_in        = powered_ff;
      warmup_left_in    = warmup_left_ff;
      warmup_running_in = warmup_running_ff;
      linger_left_in    = linger_left_ff;
      linger_running_in = linger_running_ff;
      last_reading_in   = last_reading_ff;
      prox_out_in       = prox_out_ff;
      lid_out_in        = lid_out_ff;
      reason_bits_in    = reason_bits_ff;
      context_flags_in  = context_flags_ff;

      if (fire) begin
         unique case (req_mode_ff) inside
            MODE_READING: begin
               if (powered_ff) begin
                  last_reading_in = req_covered_ff ? STATE_CLOSED : STATE_OPEN;
                  if (!warmup_running_ff) begin
                     pub_en    = 1'b1;
                     pub_value = last_reading_in;
                  end
               end
            end
            MODE_TICK: begin
               if (warmup_running_ff) begin
                  if (warmup_left_ff <= TICKS_WIDTH'(1)) begin
                     warmup_left_in    = '0;
                     warmup_running_in = 1'b0;
                     if (powered_ff) begin
                        pub_en    = 1'b1;
                        pub_value = last_reading_ff;
                     end
                  end else begin
                     warmup_left_in = warmup_left_ff - TICKS_WIDTH'(1);
                  end
               end
               if (linger_running_ff) begin
                  if (linger_left_ff <= TICKS_WIDTH'(1)) begin
                     power_set = 1'b1;
                     power_on  = 1'b0;
                  end else begin
                     linger_left_in = linger_left_ff - TICKS_WIDTH'(1);
                  end
               end
            end
            MODE_CONTEXT: begin
               context_flags_in = req_context_ff;
               reeval_en        = (req_context_ff != context_flags_ff);
            end
            MODE_REASON_ADD, MODE_REASON_REMOVE: begin
               if (|reason_hit) begin
                  if (req_mode_ff == MODE_REASON_ADD) begin
                     reason_bits_in = reason_bits_ff | reason_hit;
                  end else begin
                     reason_bits_in = reason_bits_ff & ~reason_hit;
                  end
                  reeval_en = (|reason_bits_in) != (|reason_bits_ff);
               end
            end
            MODE_REEVALUATE: begin
               reeval_en = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // publish a reading before any power change of the same request
      if (pub_en) begin
         if (acts_as_lid_ff) begin
            lid_out_in = pub_value;
         end else begin
            prox_out_in = pub_value;
         end
      end

      if (reeval_en) begin
         if (!sensor_in_use_ff || !on_demand_ff ||
             (context_flags_in != '0) || (reason_bits_in != '0)) begin
            power_set = 1'b1;
            power_on  = sensor_in_use_ff;
         end else if (powered_ff && !linger_running_ff) begin
            linger_left_in    = linger_ticks_ff;
            linger_running_in = 1'b1;
         end
      end

      if (power_set) begin
         linger_running_in = 1'b0;
         linger_left_in    = '0;
         if (powered_ff != power_on) begin
            powered_in = power_on;
            if (power_on) begin
               warmup_left_in    = warmup_ticks_ff;
               warmup_running_in = 1'b1;
            end else begin
               warmup_left_in    = '0;
               warmup_running_in = 1'b0;
               if (acts_as_lid_ff) begin
                  lid_out_in = STATE_UNDEFINED;
               end else begin
                  prox_out_in = STATE_UNDEFINED;
               end
            end
         end
      end

      // fake value while the sensor is out of use
      if (reeval_en && !sensor_in_use_ff) begin
         if (acts_as_lid_ff) begin
            lid_out_in = STATE_UNDEFINED;
         end else begin
            prox_out_in = STATE_OPEN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_in_use_ff <= 1'b1;
         on_demand_ff     <= 1'b1;
         acts_as_lid_ff   <= 1'b0;
         linger_ticks_ff  <= LINGER_TICKS_RESET;
         warmup_ticks_ff  <= WARMUP_TICKS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SENSOR_IN_USE: sensor_in_use_ff <= csr_data[0];
            CSR_ON_DEMAND:     on_demand_ff     <= csr_data[0];
            CSR_ACTS_AS_LID:   acts_as_lid_ff   <= csr_data[0];
            CSR_LINGER_TICKS:  linger_ticks_ff  <= csr_data[TICKS_WIDTH-1:0];
            CSR_WARMUP_TICKS:  warmup_ticks_ff  <= csr_data[TICKS_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         powered_ff        <= 1'b0;
         warmup_left_ff    <= '0;
         warmup_running_ff <= 1'b0;
         linger_left_ff    <= '0;
         linger_running_ff <= 1'b0;
         last_reading_ff   <= STATE_UNDEFINED;
         prox_out_ff       <= STATE_UNDEFINED;
         lid_out_ff        <= STATE_UNDEFINED;
         reason_bits_ff    <= '0;
         context_flags_ff  <= '0;
      end else begin
         req_valid_ff      <= req_valid_in;
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
         powered_ff        <= powered_in;
         warmup_left_ff    <= warmup_left_in;
         warmup_running_ff <= warmup_running_in;
         linger_left_ff    <= linger_left_in;
         linger_running_ff <= linger_running_in;
         last_reading_ff   <= last_reading_in;
         prox_out_ff       <= prox_out_in;
         lid_out_ff        <= lid_out_in;
         reason_bits_ff    <= reason_bits_in;
         context_flags_ff  <= context_flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_mode_ff      <= req_mode;
         req_covered_ff   <= req_covered;
         req_context_ff   <= {req_ui_exception, req_alarm_live, req_call_live,
                              req_lpm_current, req_lpm_next};
         req_reason_id_ff <= req_reason_id;
      end
      if (fire) begin
         rsp_proximity_state_ff <= prox_out_in;
         rsp_lid_state_ff       <= lid_out_in;
         rsp_sensor_powered_ff  <= powered_in;
         rsp_warming_up_ff      <= warmup_running_in;
         rsp_lingering_ff       <= linger_running_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_proximity_state = rsp_proximity_state_ff;
   assign rsp_lid_state       = rsp_lid_state_ff;
   assign rsp_sensor_powered  = rsp_sensor_powered_ff;
   assign rsp_warming_up      = rsp_warming_up_ff;
   assign rsp_lingering       = rsp_lingering_ff;

endmodule

`default_nettype wire

FILE: src/pspm_checker.sv
`default_nettype none

module pspm_checker
   import pspm_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_proximity_state,
   input wire logic [1:0] rsp_lid_state,
   input wire logic       rsp_sensor_powered,
   input wire logic       rsp_warming_up,
   input wire logic       rsp_lingering
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_proximity_state) &&
         $stable(rsp_lid_state) && $stable(rsp_sensor_powered) &&
         $stable(rsp_warming_up) && $stable(rsp_lingering))
      else $error("response changed while stalled");

   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || !rsp_stall |-> !req_stall)
      else $error("request stalled while the response side moves");

   a_timers_need_power: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sensor_powered |-> !rsp_warming_up && !rsp_lingering)
      else $error("warm-up or linger running while unpowered");

   a_states_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_proximity_state != 2'd3 && rsp_lid_state != 2'd3)
      else $error("illegal cover state published");

endmodule

bind proximity_sensor_power_manager pspm_checker u_pspm_checker (.*);

`default_nettype wire
